[hw/rtl/dsrs_pkg.sv]
// ============================================================================
// dsrs_pkg: shared types, constants and microcode for the secant root search
// Holds the fixed-point widths, the payload structs of both channels, the
// control word layout, its codes, the saturation helper and the program ROM.
// ============================================================================
package dsrs_pkg;

    // Q16.16 signed fixed point
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int ITER_W    = 16;
    // 33 x 32 signed products and differences of two 32 x 32 products
    localparam int PROD_W    = 2 * DATA_W + 1;
    localparam int DEN_W     = DATA_W + 1;
    localparam int NMAG_W    = 2 * DATA_W;
    localparam int CNT_W     = $clog2(NMAG_W);
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_GUESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELAXATION      = 2'd3;

    // search phase
    localparam logic [1:0] PH_IDLE        = 2'd0;
    localparam logic [1:0] PH_WAIT_BASE   = 2'd1;
    localparam logic [1:0] PH_WAIT_SECOND = 2'd2;

    // multiplier operand selection
    localparam logic [2:0] MUL_NONE       = 3'd0;
    localparam logic [2:0] MUL_Y_GAIN     = 3'd1;
    localparam logic [2:0] MUL_XB_YA      = 3'd2;
    localparam logic [2:0] MUL_XA_Y       = 3'd3;
    localparam logic [2:0] MUL_DIFF_RELAX = 3'd4;

    // register write-back operation
    localparam logic [3:0] ALU_NOP       = 4'd0;
    localparam logic [3:0] ALU_START     = 4'd1;
    localparam logic [3:0] ALU_OFFSET    = 4'd2;
    localparam logic [3:0] ALU_SECOND    = 4'd3;
    localparam logic [3:0] ALU_ACC_LOAD  = 4'd4;
    localparam logic [3:0] ALU_ACC_SUB   = 4'd5;
    localparam logic [3:0] ALU_DIV_START = 4'd6;
    localparam logic [3:0] ALU_EST_QUOT  = 4'd7;
    localparam logic [3:0] ALU_EST_FLAT  = 4'd8;
    localparam logic [3:0] ALU_ROUND_INC = 4'd9;
    localparam logic [3:0] ALU_BASE_NEXT = 4'd10;

    // jump conditions
    localparam logic [2:0] JMP_NONE       = 3'd0;
    localparam logic [2:0] JMP_ALWAYS     = 3'd1;
    localparam logic [2:0] JMP_ZERO_COUNT = 3'd2;
    localparam logic [2:0] JMP_FLAT       = 3'd3;
    localparam logic [2:0] JMP_DIV_BUSY   = 3'd4;
    localparam logic [2:0] JMP_LAST_ROUND = 3'd5;

    // result emission; every emit ends the program
    localparam logic [2:0] EMIT_NONE         = 3'd0;
    localparam logic [2:0] EMIT_PROBE_INIT   = 3'd1;
    localparam logic [2:0] EMIT_PROBE_SECOND = 3'd2;
    localparam logic [2:0] EMIT_PROBE_BASE   = 3'd3;
    localparam logic [2:0] EMIT_DONE_EST     = 3'd4;
    localparam logic [2:0] EMIT_DONE_INIT    = 3'd5;

    // program layout
    localparam int PC_W     = 5;
    localparam int PROG_LEN = 19;
    localparam logic [PC_W-1:0] ENTRY_START  = 5'd0;
    localparam logic [PC_W-1:0] ENTRY_BASE   = 5'd3;
    localparam logic [PC_W-1:0] ENTRY_SECOND = 5'd7;
    localparam logic [PC_W-1:0] LBL_DONE_INIT = 5'd2;
    localparam logic [PC_W-1:0] LBL_DIV_WAIT  = 5'd11;
    localparam logic [PC_W-1:0] LBL_EST_FLAT  = 5'd13;
    localparam logic [PC_W-1:0] LBL_ROUND     = 5'd14;
    localparam logic [PC_W-1:0] LBL_FINISH    = 5'd18;

    typedef struct packed {
        logic                     start_req;
        logic signed [DATA_W-1:0] function_value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] probe_point;
        logic                     probe_valid;
        logic signed [DATA_W-1:0] root_estimate;
        logic                     done_res;
        logic                     flat_divisor;
        logic                     saturated;
    } result_t;

    typedef struct packed {
        logic                     clamp;
        logic signed [DATA_W-1:0] value;
    } sat_t;

    typedef struct packed {
        logic busy;
        logic clamp;
    } div_stat_t;

    typedef struct packed {
        logic [2:0]      mul_sel;
        logic [3:0]      alu_op;
        logic [2:0]      jmp;
        logic [PC_W-1:0] target;
        logic [2:0]      emit;
    } ucw_t;

    // clamp a wide signed value to the data range
    function automatic sat_t dsrs_sat(input logic signed [PROD_W-1:0] v);
        sat_t r;
        logic ovf;
        ovf = !((&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1]));
        r.clamp = ovf;
        if (!ovf)
            r.value = v[DATA_W-1:0];
        else if (v[PROD_W-1])
            r.value = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r.value = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

    function automatic ucw_t uc_word(input logic [2:0] mul_sel, input logic [3:0] alu_op,
                                     input logic [2:0] jmp, input logic [PC_W-1:0] target,
                                     input logic [2:0] emit);
        ucw_t w;
        w.mul_sel = mul_sel;
        w.alu_op  = alu_op;
        w.jmp     = jmp;
        w.target  = target;
        w.emit    = emit;
        return w;
    endfunction

    // program ROM
    function automatic ucw_t dsrs_ucode(input logic [PC_W-1:0] pc);
        ucw_t w;
        case (pc)
            // start: load the base, branch on a zero round count
            5'd0:  w = uc_word(MUL_NONE, ALU_START, JMP_ZERO_COUNT, LBL_DONE_INIT, EMIT_NONE);
            5'd1:  w = uc_word(MUL_NONE, ALU_NOP, JMP_NONE, '0, EMIT_PROBE_INIT);
            5'd2:  w = uc_word(MUL_NONE, ALU_NOP, JMP_NONE, '0, EMIT_DONE_INIT);
            // value at the base: form the second probe
            5'd3:  w = uc_word(MUL_Y_GAIN, ALU_NOP, JMP_NONE, '0, EMIT_NONE);
            5'd4:  w = uc_word(MUL_NONE, ALU_OFFSET, JMP_NONE, '0, EMIT_NONE);
            5'd5:  w = uc_word(MUL_NONE, ALU_SECOND, JMP_NONE, '0, EMIT_NONE);
            5'd6:  w = uc_word(MUL_NONE, ALU_NOP, JMP_NONE, '0, EMIT_PROBE_SECOND);
            // value at the second probe: secant estimate
            5'd7:  w = uc_word(MUL_XB_YA, ALU_NOP, JMP_FLAT, LBL_EST_FLAT, EMIT_NONE);
            5'd8:  w = uc_word(MUL_XA_Y, ALU_ACC_LOAD, JMP_NONE, '0, EMIT_NONE);
            5'd9:  w = uc_word(MUL_NONE, ALU_ACC_SUB, JMP_NONE, '0, EMIT_NONE);
            5'd10: w = uc_word(MUL_NONE, ALU_DIV_START, JMP_NONE, '0, EMIT_NONE);
            5'd11: w = uc_word(MUL_NONE, ALU_NOP, JMP_DIV_BUSY, LBL_DIV_WAIT, EMIT_NONE);
            5'd12: w = uc_word(MUL_NONE, ALU_EST_QUOT, JMP_ALWAYS, LBL_ROUND, EMIT_NONE);
            5'd13: w = uc_word(MUL_NONE, ALU_EST_FLAT, JMP_NONE, '0, EMIT_NONE);
            5'd14: w = uc_word(MUL_NONE, ALU_ROUND_INC, JMP_NONE, '0, EMIT_NONE);
            5'd15: w = uc_word(MUL_DIFF_RELAX, ALU_NOP, JMP_LAST_ROUND, LBL_FINISH, EMIT_NONE);
            5'd16: w = uc_word(MUL_NONE, ALU_BASE_NEXT, JMP_NONE, '0, EMIT_NONE);
            5'd17: w = uc_word(MUL_NONE, ALU_NOP, JMP_NONE, '0, EMIT_PROBE_BASE);
            5'd18: w = uc_word(MUL_NONE, ALU_NOP, JMP_NONE, '0, EMIT_DONE_EST);
            default: w = uc_word(MUL_NONE, ALU_NOP, JMP_NONE, '0, EMIT_DONE_EST);
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/dsrs_div.sv]
// ============================================================================
// dsrs_div: radix-2 signed divider with saturating quotient
// Restoring division of a 64-bit magnitude by a 33-bit magnitude, one
// quotient bit per cycle; the quotient truncates toward zero and clamps.
// ============================================================================
module dsrs_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [dsrs_pkg::PROD_W-1:0]    num,
    input  logic signed [dsrs_pkg::DEN_W-1:0]     den,
    output dsrs_pkg::div_stat_t                   stat,
    output logic signed [dsrs_pkg::DATA_W-1:0]    quot
);
    import dsrs_pkg::*;

    logic                    busy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [NMAG_W-1:0]       q_reg;
    logic [DEN_W-1:0]        dmag_reg;
    logic                    neg_reg;

    logic signed [PROD_W-1:0] num_abs;
    logic signed [DEN_W-1:0]  den_abs;
    logic [DEN_W:0]           trial;
    logic [DEN_W:0]           diff;
    logic                     ge;
    logic                     big_pos;
    logic                     big_neg;
    logic [DATA_W-1:0]        q_low_neg;

    assign num_abs = num[PROD_W-1] ? -num : num;
    assign den_abs = den[DEN_W-1] ? -den : den;

    assign trial = {rem_reg, q_reg[NMAG_W-1]};
    assign diff  = trial - {1'b0, dmag_reg};
    assign ge    = !diff[DEN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NMAG_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            q_reg    <= num_abs[NMAG_W-1:0];
            dmag_reg <= den_abs;
            neg_reg  <= num[PROD_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_reg   <= {q_reg[NMAG_W-2:0], ge};
        end
    end

    // clamp: positive beyond max, or negative beyond min
    assign big_pos   = |q_reg[NMAG_W-1:DATA_W-1];
    assign big_neg   = (|q_reg[NMAG_W-1:DATA_W]) ||
                       (q_reg[DATA_W-1] && (|q_reg[DATA_W-2:0]));
    assign q_low_neg = -q_reg[DATA_W-1:0];

    always_comb
    begin
        stat.busy  = busy_reg;
        stat.clamp = neg_reg ? big_neg : big_pos;
        if (neg_reg)
            quot = big_neg ? {1'b1, {(DATA_W-1){1'b0}}} : q_low_neg;
        else
            quot = big_pos ? {1'b0, {(DATA_W-1){1'b1}}} : q_reg[DATA_W-1:0];
    end

endmodule

[hw/rtl/damped_secant_root_search.sv]
// ============================================================================
// damped_secant_root_search: microcoded damped secant root search
// Drives a root search on an outside function in Q16.16 signed fixed point,
// emitting probe points and taking back the function value at each probe.
// ============================================================================
//
// Usage
//   item channel   : a transfer with start_req=1 begins a search and returns
//                    the initial guess as the first probe (or the guess with
//                    done_res at once when iteration_count is zero). A
//                    transfer with start_req=0 supplies the function value at
//                    the last probe. A value while no search runs is dropped
//                    and returns nothing.
//   result channel : one result per start or in-search value transfer: either the next
//                    probe (probe_valid) or the final estimate (done_res),
//                    with the sticky flat_divisor and saturated flags.
//   cfg channel    : always ready; write only while the block is idle.
// Steps (accept to result register): a start loads the guess and emits it; the value
//   at a base point is scaled by the gain to form the second probe; the value at a
//   second probe forms the secant estimate through the radix-2 divider (skipped when
//   flat); the next item is taken after the emit, one item at a time.
// Reset clears the sequencer, flags and result valid and loads the
//   register defaults (guess 0, 16 rounds, gain 1.0, relaxation 1.0).
// A stalled receiver holds the result; the next item is still accepted and
//   processed up to its emit step, where the sequencer waits for the slot.
//
module damped_secant_root_search (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  dsrs_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output dsrs_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dsrs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dsrs_pkg::DATA_W-1:0]          cfg_data
);
    import dsrs_pkg::*;

    // configuration registers
    logic signed [DATA_W-1:0] initial_guess_reg;
    logic [ITER_W-1:0]        iteration_count_reg;
    logic signed [DATA_W-1:0] step_gain_reg;
    logic signed [DATA_W-1:0] relaxation_reg;

    // sequencer
    logic             busy_reg;
    logic [PC_W-1:0]  pc_reg;
    logic [1:0]       phase_reg;
    ucw_t             cw;
    logic             emit_stall;
    logic             step_go;
    logic             jump_take;

    // datapath
    logic signed [DATA_W-1:0] y_reg;
    logic signed [DATA_W-1:0] base_reg;
    logic signed [DATA_W-1:0] base_value_reg;
    logic signed [DATA_W-1:0] second_reg;
    logic signed [DATA_W-1:0] tmp_reg;
    logic signed [DATA_W-1:0] est_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [ITER_W-1:0]        rounds_reg;
    logic                     flat_reg;
    logic                     sat_reg;

    logic signed [DEN_W-1:0]  mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DEN_W-1:0]  est_diff;
    logic signed [PROD_W-1:0] prod_neg;
    logic signed [PROD_W-1:0] off_wide;
    logic signed [PROD_W-1:0] second_wide;
    logic signed [PROD_W-1:0] base_wide;
    sat_t                     off_sat;
    sat_t                     second_sat;
    sat_t                     base_sat;

    // divider
    logic                     div_start;
    logic signed [DEN_W-1:0]  div_den;
    div_stat_t                div_stat;
    logic signed [DATA_W-1:0] div_quot;

    // output register
    logic    result_valid_reg;
    result_t result_reg;
    result_t res_next;
    logic [1:0] phase_next;

    assign cfg_ready  = 1'b1;
    assign item_ready = !busy_reg;

    // ------------------------------------------------------------------
    // Configuration: the block does not enforce it, but it must be written only while idle
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_guess_reg   <= '0;
            iteration_count_reg <= ITER_W'(16);
            step_gain_reg       <= DATA_W'(1) << FRAC_W;
            relaxation_reg      <= DATA_W'(1) << FRAC_W;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INITIAL_GUESS:   initial_guess_reg   <= cfg_data;
                REG_ITERATION_COUNT: iteration_count_reg <= cfg_data[ITER_W-1:0];
                REG_STEP_GAIN:       step_gain_reg       <= cfg_data;
                REG_RELAXATION:      relaxation_reg      <= cfg_data;
                default:             initial_guess_reg   <= initial_guess_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: fetch the control word, stall an emit on a full output
    // ------------------------------------------------------------------
    assign cw         = dsrs_ucode(pc_reg);
    assign emit_stall = (cw.emit != EMIT_NONE) && result_valid_reg && !result_ready;
    assign step_go    = busy_reg && !emit_stall;

    always_comb
    begin
        case (cw.jmp)
            JMP_NONE:       jump_take = 1'b0;
            JMP_ALWAYS:     jump_take = 1'b1;
            JMP_ZERO_COUNT: jump_take = (iteration_count_reg == '0);
            JMP_FLAT:       jump_take = (base_value_reg == y_reg);
            JMP_DIV_BUSY:   jump_take = div_stat.busy;
            JMP_LAST_ROUND: jump_take = (rounds_reg >= iteration_count_reg);
            default:        jump_take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pc_reg    <= ENTRY_START;
            phase_reg <= PH_IDLE;
        end
        else if (item_valid && item_ready)
        begin
            // dispatch on the kind of transfer and the search phase
            if (item.start_req)
            begin
                pc_reg   <= ENTRY_START;
                busy_reg <= 1'b1;
            end
            else if (phase_reg == PH_WAIT_BASE)
            begin
                pc_reg   <= ENTRY_BASE;
                busy_reg <= 1'b1;
            end
            else if (phase_reg == PH_WAIT_SECOND)
            begin
                pc_reg   <= ENTRY_SECOND;
                busy_reg <= 1'b1;
            end
        end
        else if (step_go)
        begin
            if (cw.emit != EMIT_NONE)
            begin
                busy_reg  <= 1'b0;
                phase_reg <= phase_next;
            end
            else
                pc_reg <= jump_take ? cw.target : pc_reg + PC_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Datapath: one shared multiplier, adders and clamps
    // ------------------------------------------------------------------
    assign est_diff = DEN_W'(est_reg) - DEN_W'(second_reg);

    always_comb
    begin
        case (cw.mul_sel)
            MUL_Y_GAIN:
            begin
                mul_a = DEN_W'(y_reg);
                mul_b = step_gain_reg;
            end
            MUL_XB_YA:
            begin
                mul_a = DEN_W'(second_reg);
                mul_b = base_value_reg;
            end
            MUL_XA_Y:
            begin
                mul_a = DEN_W'(base_reg);
                mul_b = y_reg;
            end
            MUL_DIFF_RELAX:
            begin
                mul_a = est_diff;
                mul_b = relaxation_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // floor by 2^FRAC_W is an arithmetic shift
    assign prod_neg    = -prod_reg;
    assign off_wide    = prod_neg >>> FRAC_W;
    assign off_sat     = dsrs_sat(off_wide);
    assign second_wide = PROD_W'(base_reg) + PROD_W'(tmp_reg);
    assign second_sat  = dsrs_sat(second_wide);
    assign base_wide   = PROD_W'(second_reg) + (prod_reg >>> FRAC_W);
    assign base_sat    = dsrs_sat(base_wide);

    assign div_start = step_go && (cw.alu_op == ALU_DIV_START);
    assign div_den   = DEN_W'(base_value_reg) - DEN_W'(y_reg);

    dsrs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // sticky flags and round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_reg   <= 1'b0;
            sat_reg    <= 1'b0;
            rounds_reg <= '0;
        end
        else if (step_go)
        begin
            case (cw.alu_op)
                ALU_START:
                begin
                    flat_reg   <= 1'b0;
                    sat_reg    <= 1'b0;
                    rounds_reg <= '0;
                end
                ALU_OFFSET:    sat_reg    <= sat_reg | off_sat.clamp;
                ALU_SECOND:    sat_reg    <= sat_reg | second_sat.clamp;
                ALU_EST_QUOT:  sat_reg    <= sat_reg | div_stat.clamp;
                ALU_EST_FLAT:  flat_reg   <= 1'b1;
                ALU_ROUND_INC: rounds_reg <= rounds_reg + ITER_W'(1);
                ALU_BASE_NEXT: sat_reg    <= sat_reg | base_sat.clamp;
                default:       rounds_reg <= rounds_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            y_reg <= item.function_value;
        if (step_go)
        begin
            if (cw.mul_sel != MUL_NONE)
                prod_reg <= mul_p;
            case (cw.alu_op)
                ALU_START:    base_reg <= initial_guess_reg;
                ALU_OFFSET:   tmp_reg  <= off_sat.value;
                ALU_SECOND:
                begin
                    second_reg     <= second_sat.value;
                    base_value_reg <= y_reg;
                end
                ALU_ACC_LOAD:  acc_reg  <= prod_reg;
                ALU_ACC_SUB:   acc_reg  <= acc_reg - prod_reg;
                ALU_EST_QUOT:  est_reg  <= div_quot;
                ALU_EST_FLAT:  est_reg  <= second_reg;
                ALU_BASE_NEXT: base_reg <= base_sat.value;
                default:       tmp_reg  <= tmp_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result formation and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        res_next.probe_point   = '0;
        res_next.probe_valid   = 1'b0;
        res_next.root_estimate = '0;
        res_next.done_res      = 1'b0;
        res_next.flat_divisor  = flat_reg;
        res_next.saturated     = sat_reg;
        phase_next             = PH_IDLE;
        case (cw.emit)
            EMIT_PROBE_INIT, EMIT_PROBE_BASE:
            begin
                res_next.probe_point = base_reg;
                res_next.probe_valid = 1'b1;
                phase_next           = PH_WAIT_BASE;
            end
            EMIT_PROBE_SECOND:
            begin
                res_next.probe_point = second_reg;
                res_next.probe_valid = 1'b1;
                phase_next           = PH_WAIT_SECOND;
            end
            EMIT_DONE_EST:
            begin
                res_next.root_estimate = est_reg;
                res_next.done_res      = 1'b1;
            end
            EMIT_DONE_INIT:
            begin
                res_next.root_estimate = base_reg;
                res_next.done_res      = 1'b1;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (step_go && (cw.emit != EMIT_NONE))
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_go && (cw.emit != EMIT_NONE))
            result_reg <= res_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.probe_valid ^ result.done_res))
        else $error("result is neither a single probe nor a single estimate");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.done_res) |-> (phase_reg == PH_IDLE))
        else $error("search phase not idle while a final estimate waits");

    a_load_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(busy_reg))
        else $error("result loaded without an active program");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while still iterating");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg < PC_W'(PROG_LEN)))
        else $error("program counter beyond the microcode");
`endif

endmodule
